// File: src/encoder_pid_speed_controller_macros.svh
// Assertion helpers for the encoder PID speed controller.
`ifndef ENCODER_PID_SPEED_CONTROLLER_MACROS_SVH
`define ENCODER_PID_SPEED_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/epsc_pkg.sv
package epsc_pkg;

   // Field and state widths.
   localparam int COUNT_W  = 16;
   localparam int TIMER_W  = 16;
   localparam int SCALE_W  = 8;
   localparam int GAIN_W   = 16;
   localparam int TARGET_W = 16;
   localparam int SPEED_W  = 16;
   localparam int ERROR_W  = 17;
   localparam int DIFF_W   = 18;
   localparam int SUM_W    = 32;
   localparam int DUTY_W   = 8;

   // Fixed-point format of the gains.
   localparam int GAIN_FRAC_BITS = 8;
   localparam int DUTY_MAX       = 255;

   // Product and accumulator widths of the PID step.
   localparam int PP_W    = GAIN_W + ERROR_W;
   localparam int PD_W    = GAIN_W + DIFF_W;
   localparam int PI_W    = GAIN_W + SUM_W;
   localparam int ACC_W   = PI_W + 2;
   localparam int SHIFT_W = ACC_W - GAIN_FRAC_BITS;
   localparam int DELTA_W = DUTY_W + 2;
   localparam int DUTY_SUM_W = DELTA_W + 1;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOOP_PERIOD = 3'd0,
      CSR_SPEED_SCALE = 3'd1,
      CSR_GAIN_P      = 3'd2,
      CSR_GAIN_I      = 3'd3,
      CSR_GAIN_D      = 3'd4
   } csr_index_type;

   // Item kinds on the request channel.
   typedef enum logic {
      KIND_PULSE = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   // Register reset values.
   localparam logic [TIMER_W-1:0] LOOP_PERIOD_RST = 16'd100;
   localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 8'd1;

   // Saturation limits.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

   // Bias that turns the arithmetic shift into truncation toward zero.
   localparam logic signed [ACC_W-1:0] ROUND_BIAS =
      ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

endpackage

// File: src/epsc_if.sv
// Request channel: encoder pulses and millisecond ticks.
interface epsc_req_if import epsc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic signed [TARGET_W-1:0] target_speed;

   modport source (output valid, output kind, output target_speed, input ready);
   modport sink   (input valid, input kind, input target_speed, output ready);
endinterface

// Response channel: one transfer per control update.
interface epsc_rsp_if import epsc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [DUTY_W-1:0]         drive_level;
   logic [SPEED_W-1:0]        measured_speed;
   logic signed [ERROR_W-1:0] speed_error;

   modport source (output valid, output drive_level, output measured_speed,
                   output speed_error, input ready);
   modport sink   (input valid, input drive_level, input measured_speed,
                   input speed_error, output ready);
endinterface

// File: src/encoder_pid_speed_controller.sv
// Speed regulator for one motor channel with an incremental PID step.
// The request channel carries encoder pulses and one-millisecond ticks;
// pulses bump a saturating counter, ticks advance the period timer. When
// the timer reaches the loop period, the tick starts a control update and
// the response channel later carries the new drive level, the measured
// speed and the speed error. Pulses and other ticks give no response.
// Without a stall, a request transfer is possible in every cycle. An
// update runs through a six-register pipeline (snapshot, speed and error,
// integral, the three gain multiplies, delta, duty clamp), and updates
// may follow in back-to-back cycles while the receiver takes them. When
// the receiver stalls, the pipeline stages keep filling and requests are
// still taken until the snapshot stage cannot drain.
// The csr port writes one register per cycle with csr_we; it must only be
// used while no update is in flight. Synchronous active-high reset clears
// the counter, timer, duty, integral and previous error, and sets the
// loop period to 100, the speed scale to 1 and all gains to zero.
`include "encoder_pid_speed_controller_macros.svh"

module encoder_pid_speed_controller import epsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   epsc_req_if.sink               req_chan,
   epsc_rsp_if.source             rsp_chan
);

   // Configuration registers.
   logic [TIMER_W-1:0]       loop_period_ff;
   logic [SCALE_W-1:0]       speed_scale_ff;
   logic signed [GAIN_W-1:0] gain_p_ff;
   logic signed [GAIN_W-1:0] gain_i_ff;
   logic signed [GAIN_W-1:0] gain_d_ff;

   // Controller state.
   logic [COUNT_W-1:0]       pulse_count_ff;
   logic [COUNT_W-1:0]       pulse_count_in;
   logic [TIMER_W-1:0]       period_timer_ff;
   logic [TIMER_W-1:0]       period_timer_in;
   logic [TIMER_W-1:0]       timer_next;
   logic [DUTY_W-1:0]        pwm_ff;
   logic [DUTY_W-1:0]        pwm_in;
   logic signed [SUM_W-1:0]  error_sum_ff;
   logic signed [SUM_W-1:0]  error_sum_in;
   logic signed [DIFF_W-1:0] prev_error_ff;

   // Pipeline stages.
   logic                       v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic [COUNT_W-1:0]         cnt1_ff;
   logic signed [TARGET_W-1:0] tgt1_ff;
   logic [SPEED_W-1:0]         spd2_ff, spd3_ff, spd4_ff, spd5_ff, spd_out_ff;
   logic signed [ERROR_W-1:0]  err2_ff, err3_ff, err4_ff, err5_ff, err_out_ff;
   logic signed [DIFF_W-1:0]   dif3_ff;
   logic signed [SUM_W-1:0]    esum3_ff;
   logic signed [PP_W-1:0]     pp4_ff;
   logic signed [PD_W-1:0]     pd4_ff;
   logic signed [PI_W-1:0]     pi4_ff;
   logic signed [DELTA_W-1:0]  delta5_ff;

   // Stage next values.
   logic [COUNT_W+SCALE_W-1:0] speed_prod;
   logic [SPEED_W-1:0]         spd2_in;
   logic [TARGET_W-1:0]        abs_target;
   logic signed [ERROR_W-1:0]  err2_in;
   logic signed [SUM_W:0]      esum_wide;
   logic signed [DIFF_W-1:0]   dif3_in;
   logic signed [PP_W-1:0]     pp4_in;
   logic signed [PD_W-1:0]     pd4_in;
   logic signed [PI_W-1:0]     pi4_in;
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-1:0]    acc_adj;
   logic signed [SHIFT_W-1:0]  acc_shift;
   logic signed [DELTA_W-1:0]  delta5_in;
   logic signed [DUTY_SUM_W-1:0] duty_sum;

   // Handshake and stage movement.
   logic free_out, free5, free4, free3, free2, free1;
   logic ld_out, ld5, ld4, ld3, ld2, ld1;
   logic req_xfer, tick_xfer, pulse_xfer, update_due;

   assign free_out = !rsp_valid_ff || rsp_chan.ready;
   assign ld_out   = v5_ff && free_out;
   assign free5    = !v5_ff || ld_out;
   assign ld5      = v4_ff && free5;
   assign free4    = !v4_ff || ld5;
   assign ld4      = v3_ff && free4;
   assign free3    = !v3_ff || ld4;
   assign ld3      = v2_ff && free3;
   assign free2    = !v2_ff || ld3;
   assign ld2      = v1_ff && free2;
   assign free1    = !v1_ff || ld2;

   assign req_chan.ready = free1;
   assign req_xfer   = req_chan.valid && free1;
   assign tick_xfer  = req_xfer && (req_chan.kind == KIND_TICK);
   assign pulse_xfer = req_xfer && (req_chan.kind == KIND_PULSE);

   // Period timer: a tick that reaches the loop period starts an update.
   assign timer_next = (period_timer_ff < TIMER_MAX) ? period_timer_ff + 1'b1
                                                     : period_timer_ff;
   assign update_due = timer_next >= loop_period_ff;
   assign ld1        = tick_xfer && update_due;

   always_comb begin
      period_timer_in = period_timer_ff;
      pulse_count_in  = pulse_count_ff;
      if (tick_xfer) begin
         period_timer_in = update_due ? '0 : timer_next;
      end
      if (ld1) begin
         pulse_count_in = '0;
      end else if (pulse_xfer && (pulse_count_ff < COUNT_MAX)) begin
         pulse_count_in = pulse_count_ff + 1'b1;
      end
   end

   // Stage 2: scaled speed and error against the target magnitude.
   assign speed_prod = (COUNT_W+SCALE_W)'(cnt1_ff) * (COUNT_W+SCALE_W)'(speed_scale_ff);
   assign spd2_in    = (speed_prod > (COUNT_W+SCALE_W)'(SPEED_MAX)) ? SPEED_MAX
                                                                   : SPEED_W'(speed_prod);
   assign abs_target = tgt1_ff[TARGET_W-1] ? $unsigned(-tgt1_ff) : $unsigned(tgt1_ff);
   assign err2_in    = $signed(ERROR_W'(abs_target)) - $signed(ERROR_W'(spd2_in));

   // Stage 3: saturating integral and error difference.
   assign esum_wide = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(err2_ff);
   assign dif3_in   = DIFF_W'(err2_ff) - prev_error_ff;

   always_comb begin
      if (esum_wide[SUM_W] != esum_wide[SUM_W-1]) begin
         error_sum_in = esum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         error_sum_in = esum_wide[SUM_W-1:0];
      end
   end

   // Stage 4: the three gain products.
   assign pp4_in = PP_W'(gain_p_ff) * PP_W'(err3_ff);
   assign pd4_in = PD_W'(gain_d_ff) * PD_W'(dif3_ff);
   assign pi4_in = PI_W'(gain_i_ff) * PI_W'(esum3_ff);

   // Stage 5: sum, shift with truncation toward zero, saturate the delta.
   assign acc       = ACC_W'(pp4_ff) + ACC_W'(pi4_ff) - ACC_W'(pd4_ff);
   assign acc_adj   = acc[ACC_W-1] ? acc + ROUND_BIAS : acc;
   assign acc_shift = SHIFT_W'(acc_adj >>> GAIN_FRAC_BITS);

   always_comb begin
      if (acc_shift > SHIFT_W'(DELTA_MAX)) begin
         delta5_in = DELTA_MAX;
      end else if (acc_shift < SHIFT_W'(DELTA_MIN)) begin
         delta5_in = DELTA_MIN;
      end else begin
         delta5_in = DELTA_W'(acc_shift);
      end
   end

   // Output stage: new duty clamped to the PWM range.
   assign duty_sum = $signed({{(DUTY_SUM_W-DUTY_W){1'b0}}, pwm_ff})
                   + DUTY_SUM_W'(delta5_ff);

   always_comb begin
      if (duty_sum < 0) begin
         pwm_in = '0;
      end else if (duty_sum > DUTY_SUM_W'(DUTY_MAX)) begin
         pwm_in = DUTY_W'(DUTY_MAX);
      end else begin
         pwm_in = duty_sum[DUTY_W-1:0];
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_period_ff <= LOOP_PERIOD_RST;
         speed_scale_ff <= SPEED_SCALE_RST;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOOP_PERIOD: loop_period_ff <= csr_wdata[TIMER_W-1:0];
            CSR_SPEED_SCALE: speed_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_GAIN_P:      gain_p_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:      gain_i_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:      gain_d_ff      <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff  <= '0;
         period_timer_ff <= '0;
         pwm_ff          <= '0;
         error_sum_ff    <= '0;
         prev_error_ff   <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         v4_ff           <= 1'b0;
         v5_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pulse_count_ff  <= pulse_count_in;
         period_timer_ff <= period_timer_in;
         if (ld3) begin
            error_sum_ff  <= error_sum_in;
            prev_error_ff <= DIFF_W'(err2_ff);
         end
         if (ld_out) begin
            pwm_ff <= pwm_in;
         end
         v1_ff        <= ld1 || (v1_ff && !ld2);
         v2_ff        <= ld2 || (v2_ff && !ld3);
         v3_ff        <= ld3 || (v3_ff && !ld4);
         v4_ff        <= ld4 || (v4_ff && !ld5);
         v5_ff        <= ld5 || (v5_ff && !ld_out);
         rsp_valid_ff <= ld_out || (rsp_valid_ff && !rsp_chan.ready);
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (ld1) begin
         cnt1_ff <= pulse_count_ff;
         tgt1_ff <= req_chan.target_speed;
      end
      if (ld2) begin
         spd2_ff <= spd2_in;
         err2_ff <= err2_in;
      end
      if (ld3) begin
         spd3_ff  <= spd2_ff;
         err3_ff  <= err2_ff;
         dif3_ff  <= dif3_in;
         esum3_ff <= error_sum_in;
      end
      if (ld4) begin
         spd4_ff <= spd3_ff;
         err4_ff <= err3_ff;
         pp4_ff  <= pp4_in;
         pd4_ff  <= pd4_in;
         pi4_ff  <= pi4_in;
      end
      if (ld5) begin
         spd5_ff   <= spd4_ff;
         err5_ff   <= err4_ff;
         delta5_ff <= delta5_in;
      end
      if (ld_out) begin
         spd_out_ff <= spd5_ff;
         err_out_ff <= err5_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drive_level    = pwm_ff;
   assign rsp_chan.measured_speed = spd_out_ff;
   assign rsp_chan.speed_error    = err_out_ff;

   // The duty only moves when an update reaches the output register.
   `EPSC_ASSERT_NEXT(a_duty_hold, clock, reset, !ld_out, $stable(pwm_ff),
      "Duty changed without an output transfer")
   // A counted pulse raises the counter by exactly one.
   `EPSC_ASSERT_NEXT(a_pulse_count, clock, reset,
      pulse_xfer && (pulse_count_ff != COUNT_MAX),
      pulse_count_ff == $past(pulse_count_ff) + 16'd1,
      "Pulse counter did not advance")
   // An update tick takes a snapshot and clears the counter.
   `EPSC_ASSERT_NEXT(a_update_snapshot, clock, reset, ld1,
      v1_ff && (pulse_count_ff == '0) && (period_timer_ff == '0),
      "Update tick did not restart the measurement")
   // A finished delta waits while the output register is blocked.
   `EPSC_ASSERT_NEXT(a_delta_hold, clock, reset, v5_ff && !free_out, v5_ff,
      "Delta stage dropped an update under stall")

endmodule

// File: tb/tb_top.sv
module tb_top;
   import epsc_pkg::*;

   localparam int SETTLE_CYCLES   = 12;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int MAX_REPORTS     = 20;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 68;

   // One control update as seen on the response channel.
   typedef struct {
      logic [DUTY_W-1:0]         drive_level;
      logic [SPEED_W-1:0]        measured_speed;
      logic signed [ERROR_W-1:0] speed_error;
   } update_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   epsc_req_if req_bus ();
   epsc_rsp_if rsp_bus ();

   encoder_pid_speed_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #10 clock = ~clock;

   // Predicted copy of the controller settings.
   logic [TIMER_W-1:0]        cfg_period;
   logic [SCALE_W-1:0]        cfg_scale;
   logic signed [GAIN_W-1:0]  cfg_gain_p;
   logic signed [GAIN_W-1:0]  cfg_gain_i;
   logic signed [GAIN_W-1:0]  cfg_gain_d;

   // Predicted copy of the controller state.
   logic [COUNT_W-1:0] pulse_cnt;
   logic [TIMER_W-1:0] period_tmr;
   logic [DUTY_W-1:0]  duty_level;
   longint             integral_sum;
   longint             last_error;

   update_result_type pending_updates[$];

   int unsigned error_count     = 0;
   int unsigned requests_seen   = 0;
   int unsigned updates_checked = 0;
   int unsigned idle_cycles     = 0;
   bit          idling_on       = 1'b1;
   int unsigned send_quiet_left = 0;
   int unsigned rsp_quiet_left  = 0;
   int unsigned rsp_hold_left   = 0;
   int unsigned rsp_roll;

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: mismatch: %s", $time, msg);
      end
   endtask

   task automatic reset_model();
      cfg_period   = LOOP_PERIOD_RST;
      cfg_scale    = SPEED_SCALE_RST;
      cfg_gain_p   = '0;
      cfg_gain_i   = '0;
      cfg_gain_d   = '0;
      pulse_cnt    = '0;
      period_tmr   = '0;
      duty_level   = '0;
      integral_sum = 0;
      last_error   = 0;
      pending_updates.delete();
   endtask

   task automatic apply_setting(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LOOP_PERIOD: cfg_period = data;
         CSR_SPEED_SCALE: cfg_scale = data[SCALE_W-1:0];
         CSR_GAIN_P:      cfg_gain_p = data;
         CSR_GAIN_I:      cfg_gain_i = data;
         CSR_GAIN_D:      cfg_gain_d = data;
         default: ;
      endcase
   endtask

   // Pulses bump the counter; a tick that completes the period runs one PID step.
   task automatic predict_request(kind_type kind, logic signed [TARGET_W-1:0] target);
      longint            speed;
      longint            magnitude;
      longint            err;
      longint            sum;
      longint            acc;
      longint            step;
      longint            next_duty;
      update_result_type upd;
      requests_seen++;
      if (kind == KIND_PULSE) begin
         if (pulse_cnt != COUNT_MAX) pulse_cnt++;
         return;
      end
      if (period_tmr != TIMER_MAX) period_tmr++;
      if (period_tmr < cfg_period) return;
      period_tmr = '0;

      speed = longint'(pulse_cnt) * longint'(cfg_scale);
      if (speed > longint'(SPEED_MAX)) speed = longint'(SPEED_MAX);
      pulse_cnt = '0;

      magnitude = longint'(target);
      if (magnitude < 0) magnitude = -magnitude;
      err = magnitude - speed;

      sum = integral_sum + err;
      if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
      if (sum < longint'(SUM_MIN)) sum = longint'(SUM_MIN);
      integral_sum = sum;

      // The derivative term is subtracted; the shift truncates toward zero.
      acc = longint'(cfg_gain_p) * err
          - longint'(cfg_gain_d) * (err - last_error)
          + longint'(cfg_gain_i) * integral_sum;
      if (acc < 0) step = -((-acc) >>> GAIN_FRAC_BITS);
      else step = acc >>> GAIN_FRAC_BITS;
      last_error = err;

      next_duty = longint'(duty_level) + step;
      if (next_duty < 0) next_duty = 0;
      if (next_duty > DUTY_MAX) next_duty = DUTY_MAX;
      duty_level = DUTY_W'(next_duty);

      upd.drive_level    = duty_level;
      upd.measured_speed = SPEED_W'(speed);
      upd.speed_error    = ERROR_W'(err);
      pending_updates.push_back(upd);
   endtask

   task automatic check_update();
      update_result_type want;
      if (pending_updates.size() == 0) begin
         report_mismatch($sformatf("response with no update pending: drive %0d speed %0d error %0d",
                                   rsp_bus.drive_level, rsp_bus.measured_speed,
                                   rsp_bus.speed_error));
         return;
      end
      want = pending_updates.pop_front();
      updates_checked++;
      if (rsp_bus.drive_level !== want.drive_level) begin
         report_mismatch($sformatf("drive_level %0d, predicted %0d",
                                   rsp_bus.drive_level, want.drive_level));
      end
      if (rsp_bus.measured_speed !== want.measured_speed) begin
         report_mismatch($sformatf("measured_speed %0d, predicted %0d",
                                   rsp_bus.measured_speed, want.measured_speed));
      end
      if (rsp_bus.speed_error !== want.speed_error) begin
         report_mismatch($sformatf("speed_error %0d, predicted %0d",
                                   rsp_bus.speed_error, want.speed_error));
      end
   endtask

   // Sample all transfers and register writes at the clock edge.
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_update();
         if (req_bus.valid && req_bus.ready) begin
            predict_request(kind_type'(req_bus.kind), req_bus.target_speed);
         end
         if (csr_we) apply_setting(csr_index, csr_wdata);
      end
   end

   // Response stalls: mostly short, a few long, with stall-free stretches.
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!idling_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (rsp_quiet_left != 0) begin
         rsp_quiet_left--;
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 2) begin
            rsp_quiet_left = $urandom_range(30, 80);
            rsp_bus.ready <= 1'b1;
         end else if (rsp_roll < 20) begin
            rsp_hold_left = (rsp_roll < 18) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idling_on) return 0;
      if (send_quiet_left != 0) begin
         send_quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         send_quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic signed [TARGET_W-1:0] random_target();
      int unsigned roll;
      logic signed [TARGET_W-1:0] value;
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
         value = TARGET_W'($urandom_range(0, 2047));
         if ($urandom_range(0, 1)) value = -value;
      end else if (roll < 9) begin
         value = TARGET_W'($urandom());
      end else begin
         case ($urandom_range(0, 3))
            0:       value = 16'sh7FFF;
            1:       value = 16'sh8000;
            2:       value = '0;
            default: value = '1;
         endcase
      end
      return value;
   endfunction

   // Called at a clock edge; returns at the edge where the transfer happens.
   task automatic send_request(kind_type kind, logic signed [TARGET_W-1:0] target);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.target_speed <= target;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_pulses(int unsigned count);
      repeat (count) send_request(KIND_PULSE, random_target());
   endtask

   task automatic send_ticks(int unsigned count, logic signed [TARGET_W-1:0] target);
      repeat (count) send_request(KIND_TICK, target);
   endtask

   // Stop sending, let every update drain and the pipeline settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic csr_release();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // The upper byte of the scale write is random and must be dropped.
   task automatic write_settings(logic [TIMER_W-1:0] period, logic [SCALE_W-1:0] scale,
                                 logic signed [GAIN_W-1:0] gp, logic signed [GAIN_W-1:0] gi,
                                 logic signed [GAIN_W-1:0] gd);
      csr_write(CSR_LOOP_PERIOD, period);
      csr_write(CSR_SPEED_SCALE, {SCALE_W'($urandom()), scale});
      csr_write(CSR_GAIN_P, gp);
      csr_write(CSR_GAIN_I, gi);
      csr_write(CSR_GAIN_D, gd);
      csr_release();
   endtask

   // Reset values: period 100, scale 1, zero gains.
   task automatic test_reset_values();
      for (int i = 0; i < 100; i++) begin
         if (i % 25 == 7) send_request(KIND_PULSE, random_target());
         send_request(KIND_TICK, random_target());
      end
      wait_idle();
   endtask

   // Field extremes, zero period and scale, duty clamping and ignored indexes.
   task automatic test_directed();
      write_settings(16'd1, 8'd3, 16'sh0100, 16'sh0000, 16'sh0000);
      send_pulses(2);
      send_request(KIND_TICK, 16'sh7FFF);
      send_request(KIND_TICK, 16'sh8000);
      send_pulses(5);
      send_request(KIND_TICK, 16'sh0000);
      send_request(KIND_TICK, 16'shFFFF);
      wait_idle();

      write_settings(16'd0, 8'd0, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
      for (int idx = CSR_GAIN_D + 1; idx < 2 ** CSR_INDEX_W; idx++) begin
         csr_write(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom()));
      end
      csr_release();
      send_pulses(2);
      send_request(KIND_TICK, 16'sh7FFF);
      send_request(KIND_TICK, 16'sh8000);
      wait_idle();

      write_settings(16'd2, 8'd255, 16'sh8000, 16'sh8000, 16'sh7FFF);
      send_pulses(3);
      send_request(KIND_TICK, 16'sh0001);
      send_request(KIND_TICK, 16'sh5555);
      send_request(KIND_TICK, 16'shAAAA);
      wait_idle();
   endtask

   // Products beyond the speed range, then a small count at full scale.
   task automatic test_speed_saturation();
      idling_on = 1'b0;
      write_settings(16'd1, 8'd255, 16'sh0040, '0, 16'sh0010);
      send_pulses(258);
      send_request(KIND_TICK, 16'sh7FFF);
      idling_on = 1'b1;
      send_pulses(2);
      send_request(KIND_TICK, random_target());
      wait_idle();
   endtask

   // Longest loop period left unfinished, then lower periods, the last one below a running timer.
   task automatic test_long_period();
      write_settings(16'hFFFF, 8'd1, 16'sh0020, '0, '0);
      send_pulses(3);
      send_ticks(40, 16'sh0100);
      wait_idle();
      write_settings(16'd50, 8'd7, 16'sh0020, '0, 16'shFFF0);
      send_pulses(4);
      send_ticks(30, random_target());
      wait_idle();
      write_settings(16'd10, 8'd7, 16'sh0020, '0, 16'shFFF0);
      send_ticks(3, random_target());
      wait_idle();
   endtask

   // Random traffic over a series of settings.
   task automatic test_random();
      logic [TIMER_W-1:0]       period;
      logic [SCALE_W-1:0]       scale;
      logic signed [GAIN_W-1:0] gp;
      logic signed [GAIN_W-1:0] gi;
      logic signed [GAIN_W-1:0] gd;
      int unsigned              pulse_pct;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         period = (phase == 0) ? 16'd1 : (phase == 1) ? 16'd0 :
                  ($urandom_range(0, 4) == 0) ? 16'd20 : TIMER_W'($urandom_range(1, 6));
         scale  = (phase == 2) ? 8'd255 : (phase == 3) ? 8'd0 :
                  ($urandom_range(0, 1) ? SCALE_W'($urandom_range(1, 8))
                                        : SCALE_W'($urandom_range(1, 255)));
         if (phase == 4) begin
            gp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            gi = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            gd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         end else begin
            gp = GAIN_W'(int'($urandom_range(0, 511)) - 256);
            gd = GAIN_W'(int'($urandom_range(0, 511)) - 256);
            gi = (phase % 3 == 2) ? GAIN_W'(int'($urandom_range(0, 6)) - 3) : '0;
         end
         write_settings(period, scale, gp, gi, gd);
         pulse_pct = $urandom_range(20, 80);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < pulse_pct) send_request(KIND_PULSE, random_target());
            else send_request(KIND_TICK, random_target());
         end
         wait_idle();
      end
   endtask

   // Mixed traffic with a running integral feeding the drive level.
   task automatic test_integral_gain();
      write_settings(16'd2, 8'd9, 16'sh0030, 16'sh0004, 16'sh0008);
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 1)) send_request(KIND_PULSE, random_target());
         else send_request(KIND_TICK, random_target());
      end
      wait_idle();
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_PULSE;
      req_bus.target_speed = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed();
      test_speed_saturation();
      test_long_period();
      test_random();
      test_integral_gain();

      $display("Checked %0d control updates produced by %0d requests.",
               updates_checked, requests_seen);
      $display("Run covered speed saturation, zero period and scale, a lowered loop period, "
               , "duty clamping, integral gain and random settings.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
